FILE: sv/decimal_number_glyph_renderer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal number glyph renderer
// Concurrent checks clocked on clk_i, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_NUMBER_GLYPH_RENDERER_ASSERT_SVH
`define DECIMAL_NUMBER_GLYPH_RENDERER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define DNGR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define DNGR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: sv/dngr_pkg.sv
// ----------------------------------------------------------------------------
// dngr_pkg
// Widths, field layout and the digit glyph ROM of the glyph renderer.
// ----------------------------------------------------------------------------
package dngr_pkg;

  // Width of the conversion; the value is taken modulo 2^VALUE_BITS.
  localparam int VALUE_BITS = 32;

  // Input field widths.
  localparam int ColInWidth  = 8;
  localparam int PageWidth   = 8;
  localparam int ValueWidth  = 32;
  localparam int InDataWidth = ColInWidth + PageWidth + ValueWidth;

  // Output field widths.
  localparam int ColOutWidth  = 7;
  localparam int HalfWidth    = 64;
  localparam int DigitWidth   = 4;
  localparam int OutFieldBits = ColOutWidth + PageWidth + 2 * HalfWidth + DigitWidth;
  localparam int OutDataWidth = ((OutFieldBits + 7) / 8) * 8;

  // A 32-bit value has at most ten decimal digits.
  localparam int NumDigits  = 10;
  localparam int BcdWidth   = NumDigits * DigitWidth;
  localparam int CountWidth = $clog2(NumDigits + 1);
  localparam int StepWidth  = $clog2(ValueWidth);

  // Mask that limits the value to VALUE_BITS bits.
  localparam logic [ValueWidth-1:0] ValueMask =
    (VALUE_BITS >= ValueWidth) ? {ValueWidth{1'b1}} :
    ValueWidth'((64'd1 << VALUE_BITS) - 64'd1);

  // Column step between neighbouring digits.
  localparam logic [ColInWidth-1:0] ColStep = ColInWidth'(8);
  // Page offset applied when a digit runs past the right edge.
  localparam logic [PageWidth-1:0] PageWrapStep = PageWidth'(2);

  typedef struct packed {
    logic [HalfWidth-1:0] second_half;
    logic [HalfWidth-1:0] first_half;
  } glyph_t;

  // 8x16 glyphs of the digits, byte 0 in the lowest bits of each half.
  function automatic glyph_t digit_glyph(input logic [DigitWidth-1:0] d);
    glyph_t g;
    unique case (d)
      4'd1: begin
        g.first_half  = 64'h2010_2010_0000_0000;
        g.second_half = 64'h0000_2000_2000_3FF8;
      end
      4'd2: begin
        g.first_half  = 64'h2408_2808_3070_0000;
        g.second_half = 64'h0000_30F0_2108_2208;
      end
      4'd3: begin
        g.first_half  = 64'h2108_2008_1830_0000;
        g.second_half = 64'h0000_1C70_2288_2108;
      end
      4'd4: begin
        g.first_half  = 64'h2440_0580_0600_0000;
        g.second_half = 64'h2400_2400_3FF8_2430;
      end
      4'd5: begin
        g.first_half  = 64'h2088_2088_19F8_0000;
        g.second_half = 64'h0000_0E08_1108_2088;
      end
      4'd6: begin
        g.first_half  = 64'h2088_1110_0FE0_0000;
        g.second_half = 64'h0000_1F00_2090_2088;
      end
      4'd7: begin
        g.first_half  = 64'h3E08_0008_0018_0000;
        g.second_half = 64'h0000_0018_0068_0188;
      end
      4'd8: begin
        g.first_half  = 64'h2108_2288_1C70_0000;
        g.second_half = 64'h0000_1C70_2288_2108;
      end
      4'd9: begin
        g.first_half  = 64'h2208_1208_01F0_0000;
        g.second_half = 64'h0000_0FE0_1110_2208;
      end
      // Digit zero; codes above nine show the same glyph.
      default: begin
        g.first_half  = 64'h2008_1010_0FE0_0000;
        g.second_half = 64'h0000_0FE0_1010_2008;
      end
    endcase
    return g;
  endfunction

endpackage

FILE: sv/decimal_number_glyph_renderer.sv
// ----------------------------------------------------------------------------
// decimal_number_glyph_renderer
// Converts a binary value to decimal digits and emits one glyph per digit.
// ----------------------------------------------------------------------------
// Usage: an item on the slave stream carries a start column, a start page
// and a 32-bit unsigned value. The block produces one result item per
// decimal digit, most significant first and without leading zeros (zero
// gives a single digit). Each result carries the digit's column and page,
// its 16 glyph bytes and the digit itself; tlast marks the last digit.
// Sequence: the item is taken, then a shift-and-add-three step runs once
// per cycle over all value bits, then leading zeros are dropped at one
// digit per cycle, then one result is loaded per cycle the output register
// is free. Dropped zeros and emitted digits always add up to ten. A new
// item is taken only after the last digit of the previous one is loaded.
// The time is set by the single bit-serial conversion loop;
// s_axis_tready is high only when idle.
// Results sit in an output register; a stalled receiver holds it and the
// digit emission pauses, and the next item may be taken while the last
// result still waits. Reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module decimal_number_glyph_renderer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: start_column [7:0], start_page [15:8], value [47:16]
  input  logic [dngr_pkg::InDataWidth-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: column [6:0], page [14:7], glyph_first_half [78:15],
  //        glyph_second_half [142:79], digit_value [146:143], zeros above
  output logic [dngr_pkg::OutDataWidth-1:0] m_axis_tdata,
  output logic                              m_axis_tlast
);
  import dngr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [StepWidth-1:0]   step_q;
  logic [ValueWidth-1:0]  bin_q;
  logic [BcdWidth-1:0]    bcd_q;
  logic [BcdWidth-1:0]    bcd_adj;
  logic [CountWidth-1:0]  count_q;
  logic [ColInWidth-1:0]  col_q;
  logic [PageWidth-1:0]   page_q;

  logic                   out_valid_q;
  logic                   out_valid_d;
  logic                   out_last_q;
  logic [ColOutWidth-1:0] out_col_q;
  logic [PageWidth-1:0]   out_page_q;
  glyph_t                 out_glyph_q;
  logic [DigitWidth-1:0]  out_digit_q;

  logic                   in_fire;
  logic                   out_free;
  logic                   emit_fire;
  logic [DigitWidth-1:0]  top_digit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit_fire     = (state_q == ST_EMIT) && out_free;
  assign top_digit     = bcd_q[BcdWidth-1 -: DigitWidth];

  // The output register fills when a digit is loaded and empties once taken.
  assign out_valid_d = emit_fire || (out_valid_q && !m_axis_tready);

  // Add-three correction of every BCD digit ahead of the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitWidth +: DigitWidth] >= DigitWidth'(5)) begin
        bcd_adj[i*DigitWidth +: DigitWidth] =
          bcd_q[i*DigitWidth +: DigitWidth] + DigitWidth'(3);
      end else begin
        bcd_adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth];
      end
    end
  end

  // Sequencer, conversion registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            col_q   <= s_axis_tdata[ColInWidth-1:0];
            page_q  <= s_axis_tdata[ColInWidth +: PageWidth];
            bin_q   <= s_axis_tdata[ColInWidth+PageWidth +: ValueWidth] & ValueMask;
            bcd_q   <= '0;
            step_q  <= '0;
            count_q <= CountWidth'(NumDigits);
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_q  <= {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
          bin_q  <= {bin_q[ValueWidth-2:0], 1'b0};
          step_q <= step_q + StepWidth'(1);
          if (step_q == StepWidth'(ValueWidth - 1)) begin
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top_digit == '0 && count_q > CountWidth'(1)) begin
            bcd_q   <= {bcd_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
            count_q <= count_q - CountWidth'(1);
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_last_q  <= (count_q == CountWidth'(1));
            out_digit_q <= top_digit;
            out_glyph_q <= digit_glyph(top_digit);
            if (col_q[ColInWidth-1]) begin
              out_col_q  <= '0;
              out_page_q <= page_q + PageWrapStep;
            end else begin
              out_col_q  <= col_q[ColOutWidth-1:0];
              out_page_q <= page_q;
            end
            col_q   <= col_q + ColStep;
            bcd_q   <= {bcd_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
            count_q <= count_q - CountWidth'(1);
            if (count_q == CountWidth'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output stream packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OutDataWidth - OutFieldBits){1'b0}}, out_digit_q,
                          out_glyph_q.second_half, out_glyph_q.first_half,
                          out_page_q, out_col_q};

  // Checks on the sequencer.
  `include "decimal_number_glyph_renderer_assert.svh"

  // After the last digit is taken no result follows until a new conversion.
  `DNGR_ASSERT(a_no_result_after_last, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid, "result after last digit")
  // An accepted item starts the conversion from its first step.
  `DNGR_ASSERT(a_accept_starts_conv, in_fire |=> (state_q == ST_CONV && step_q == '0), "conversion did not start")
  // A shown digit is always a decimal digit.
  `DNGR_ASSERT(a_digit_range, m_axis_tvalid |-> (out_digit_q <= DigitWidth'(9)), "digit out of range")
  // Leading-zero removal and emission never run out of digits.
  `DNGR_ASSERT_ALWAYS(a_count_nonzero, (state_q == ST_SKIP || state_q == ST_EMIT) |-> (count_q != '0), "digit count empty")

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench of the decimal number glyph renderer
// Sends numbers with a start column and page, and predicts the digit glyph
// items that each number should produce. A short directed table covers the
// zero value, every digit, the widest value and the column and page wrap
// cases. Random numbers follow in four phases of sender and receiver
// idling. Every result item is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;

  import dngr_pkg::*;

  // Bit positions of the result fields within m_axis_tdata.
  localparam int ColLsb    = 0;
  localparam int PageLsb   = ColLsb + ColOutWidth;
  localparam int FirstLsb  = PageLsb + PageWidth;
  localparam int SecondLsb = FirstLsb + HalfWidth;
  localparam int DigitLsb  = SecondLsb + HalfWidth;

  localparam int RandomPerPhase = 32;
  localparam int SettleCycles   = 60;
  localparam int CycleLimit     = 400000;

  // Glyph halves of the digit zero.
  localparam logic [63:0] ZeroFirst  = 64'h2008_1010_0FE0_0000;
  localparam logic [63:0] ZeroSecond = 64'h0000_0FE0_1010_2008;

  // One predicted result item.
  typedef struct packed {
    logic [6:0]  column;
    logic [7:0]  page;
    logic [63:0] first_half;
    logic [63:0] second_half;
    logic [3:0]  digit;
    logic        last;
  } digit_glyph_t;

  // One number to render, with an optional typed-in single-digit result.
  typedef struct packed {
    logic [7:0]  start_col;
    logic [7:0]  start_page;
    logic [31:0] value;
    logic        typed;
    logic [6:0]  want_col;
    logic [7:0]  want_page;
  } number_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    m_axis_tlast;

  digit_glyph_t glyph_due [$];
  digit_glyph_t oldest_glyph;
  int           fail_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  // Directed numbers; zero values carry their single result typed in.
  number_row_t directed_rows [21] = '{
    '{8'd0,   8'd0,   32'd0,          1'b1, 7'd0,   8'd0},
    '{8'd127, 8'd5,   32'd0,          1'b1, 7'd127, 8'd5},
    '{8'd128, 8'd255, 32'd0,          1'b1, 7'd0,   8'd1},
    '{8'd255, 8'd254, 32'd0,          1'b1, 7'd0,   8'd0},
    '{8'd8,   8'd1,   32'd1,          1'b0, 7'd0,   8'd0},
    '{8'd16,  8'd2,   32'd2,          1'b0, 7'd0,   8'd0},
    '{8'd24,  8'd3,   32'd3,          1'b0, 7'd0,   8'd0},
    '{8'd32,  8'd4,   32'd4,          1'b0, 7'd0,   8'd0},
    '{8'd40,  8'd5,   32'd5,          1'b0, 7'd0,   8'd0},
    '{8'd48,  8'd6,   32'd6,          1'b0, 7'd0,   8'd0},
    '{8'd56,  8'd7,   32'd7,          1'b0, 7'd0,   8'd0},
    '{8'd64,  8'd8,   32'd8,          1'b0, 7'd0,   8'd0},
    '{8'd72,  8'd9,   32'd9,          1'b0, 7'd0,   8'd0},
    '{8'd0,   8'd0,   32'd10,         1'b0, 7'd0,   8'd0},
    '{8'd0,   8'd0,   32'hFFFF_FFFF,  1'b0, 7'd0,   8'd0},
    '{8'd120, 8'd3,   32'hFFFF_FFFF,  1'b0, 7'd0,   8'd0},
    '{8'd200, 8'd255, 32'd1000000000, 1'b0, 7'd0,   8'd0},
    '{8'd56,  8'd0,   32'd999999999,  1'b0, 7'd0,   8'd0},
    '{8'd250, 8'd128, 32'd1234567890, 1'b0, 7'd0,   8'd0},
    '{8'd64,  8'd64,  32'h8000_0000,  1'b0, 7'd0,   8'd0},
    '{8'd255, 8'd0,   32'hFFFF_FFFE,  1'b0, 7'd0,   8'd0}
  };

  decimal_number_glyph_renderer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Glyph bytes of a digit, byte 0 in the top bits.
  function automatic logic [127:0] glyph_bytes(input logic [3:0] d);
    case (d)
      4'd1:    return 128'h0000_0000_1020_1020_F83F_0020_0020_0000;
      4'd2:    return 128'h0000_7030_0828_0824_0822_0821_F030_0000;
      4'd3:    return 128'h0000_3018_0820_0821_0821_8822_701C_0000;
      4'd4:    return 128'h0000_0006_8005_4024_3024_F83F_0024_0024;
      4'd5:    return 128'h0000_F819_8820_8820_8820_0811_080E_0000;
      4'd6:    return 128'h0000_E00F_1011_8820_8820_9020_001F_0000;
      4'd7:    return 128'h0000_1800_0800_083E_8801_6800_1800_0000;
      4'd8:    return 128'h0000_701C_8822_0821_0821_8822_701C_0000;
      4'd9:    return 128'h0000_F001_0812_0822_0822_1011_E00F_0000;
      default: return 128'h0000_E00F_1010_0820_0820_1010_E00F_0000;
    endcase
  endfunction

  // Split a number into digits and queue one glyph item per digit.
  function automatic void render_digits(input logic [7:0] col0, input logic [7:0] page0,
                                        input logic [31:0] value);
    logic [3:0]   digits [10];
    int unsigned  rest;
    int           count;
    logic [7:0]   col;
    logic [127:0] bytes;
    digit_glyph_t item;
    rest  = value;
    count = 0;
    do begin
      digits[count] = 4'(rest % 10);
      rest = rest / 10;
      count++;
    end while (rest != 0);
    for (int t = 0; t < count; t++) begin
      item.digit = digits[count - 1 - t];
      col = col0 + 8'(8 * t);
      item.page = page0;
      // A digit past the right edge starts again at column 0, two pages down.
      if (col > 8'd127) begin
        col = 8'd0;
        item.page = page0 + 8'd2;
      end
      item.column = col[6:0];
      bytes = glyph_bytes(item.digit);
      for (int i = 0; i < 8; i++) begin
        item.first_half[8*i +: 8]  = bytes[127 - 8*i -: 8];
        item.second_half[8*i +: 8] = bytes[63 - 8*i -: 8];
      end
      item.last = (t == count - 1);
      glyph_due.push_back(item);
    end
  endfunction

  // Offer one number, wait for it to be taken, and queue its results.
  task automatic send_number(input number_row_t row);
    digit_glyph_t typed_item;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.value, row.start_page, row.start_col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (row.typed) begin
      typed_item = '{row.want_col, row.want_page, ZeroFirst, ZeroSecond, 4'd0, 1'b1};
      glyph_due.push_back(typed_item);
    end else begin
      render_digits(row.start_col, row.start_page, row.value);
    end
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (glyph_due.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Random number: random bit length, with the top of the range now and then.
  task automatic send_random_number();
    number_row_t row;
    int          len;
    row = '0;
    len = $urandom_range(32, 0);
    row.value = $urandom() >> (32 - len);
    if ($urandom_range(9) == 0) row.value = 32'hFFFF_FFFF - $urandom_range(3);
    row.start_page = 8'($urandom_range(255));
    if ($urandom_range(1) == 0) row.start_col = 8'($urandom_range(255));
    else row.start_col = 8'($urandom_range(135, 48));
    send_number(row);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: stall at random for the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each taken result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (glyph_due.size() == 0) begin
        $error("result item with none predicted: digit %0d", m_axis_tdata[DigitLsb +: 4]);
        fail_count++;
      end else begin
        oldest_glyph = glyph_due.pop_front();
        check_field("column", 64'(oldest_glyph.column), 64'(m_axis_tdata[ColLsb +: 7]));
        check_field("page", 64'(oldest_glyph.page), 64'(m_axis_tdata[PageLsb +: 8]));
        check_field("glyph_first_half", oldest_glyph.first_half,
                    m_axis_tdata[FirstLsb +: 64]);
        check_field("glyph_second_half", oldest_glyph.second_half,
                    m_axis_tdata[SecondLsb +: 64]);
        check_field("digit_value", 64'(oldest_glyph.digit), 64'(m_axis_tdata[DigitLsb +: 4]));
        check_field("last_digit", 64'(oldest_glyph.last), 64'(m_axis_tlast));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus: directed table, then four phases of random numbers.
  initial begin
    fail_count     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_number(directed_rows[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) send_random_number();
      drain_results();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
